// ----- hw/rtl/c32fd_pkg.sv -----
package c32fd_pkg;

    // Frame header bytes 'i', 'o', 't'
    localparam logic [7:0] HDR0 = 8'h69;
    localparam logic [7:0] HDR1 = 8'h6F;
    localparam logic [7:0] HDR2 = 8'h74;

    // Command codes that carry a payload length
    localparam logic [7:0] CMD_INIT   = 8'h00;
    localparam logic [7:0] CMD_STORE  = 8'h01;
    localparam logic [7:0] CMD_STATUS = 8'h03;

    // Configuration register indexes
    localparam logic [1:0] REG_INIT_LENGTH   = 2'd0;
    localparam logic [1:0] REG_STORE_LENGTH  = 2'd1;
    localparam logic [1:0] REG_STATUS_LENGTH = 2'd2;

    // Reset values of the length registers
    localparam logic [7:0] INIT_LENGTH_RST   = 8'd14;
    localparam logic [7:0] STORE_LENGTH_RST  = 8'd123;
    localparam logic [7:0] STATUS_LENGTH_RST = 8'd1;

    // Reflected CRC-32
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Frame positions
    localparam logic [8:0] POS_CMD     = 9'd3;
    localparam logic [8:0] POS_PAYLOAD = 9'd4;

endpackage

// ----- hw/rtl/crc32_frame_deframer_core.sv -----
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+---------------------------------------------
// s_        | in        | s_valid / s_ready  | s_kind, s_data_byte
// m_        | out       | m_valid / m_ready  | m_command, m_payload_byte, m_payload_offset,
//           |           |                    | m_frame_end, m_crc_ok
// cfg_      | in        | cfg_wr_en          | cfg_index, cfg_wr_data
//
// One item per cycle sustained while the result is not stalled: an item waits in the input
// register, then the frame logic and the byte-wide CRC update run into the result register.
// aresetn (synchronous, active low) restores the length registers and starts the header hunt.
// A stalled result holds the frame logic; the input register still takes one more item.
module crc32_frame_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_command,
    output logic [7:0]  m_payload_byte,
    output logic [7:0]  m_payload_offset,
    output logic        m_frame_end,
    output logic        m_crc_ok,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data
);

    logic        in_valid_reg;
    logic        in_kind_reg;
    logic [7:0]  in_byte_reg;

    logic [7:0]  init_length_reg;
    logic [7:0]  store_length_reg;
    logic [7:0]  status_length_reg;

    logic [8:0]  position_reg, position_next;
    logic [7:0]  command_reg, command_next;
    logic [7:0]  length_reg, length_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rcv_crc_reg, rcv_crc_next;

    logic        m_valid_reg;
    logic [7:0]  m_command_reg;
    logic [7:0]  m_payload_byte_reg;
    logic [7:0]  m_payload_offset_reg;
    logic        m_frame_end_reg;
    logic        m_crc_ok_reg;

    logic        advance;
    logic        res_valid;
    logic [7:0]  res_byte;
    logic [7:0]  res_offset;
    logic        res_end;
    logic        res_ok;
    logic [31:0] crc_upd;
    logic [7:0]  hdr_expect;
    logic [8:0]  pay_end;
    logic [8:0]  pos_plus;
    logic [8:0]  trail_end;

    // Process the held item when the result register is free or draining
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_byte_reg <= s_data_byte;
        end
    end

    // Length registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_length_reg   <= c32fd_pkg::INIT_LENGTH_RST;
            store_length_reg  <= c32fd_pkg::STORE_LENGTH_RST;
            status_length_reg <= c32fd_pkg::STATUS_LENGTH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                c32fd_pkg::REG_INIT_LENGTH:   init_length_reg   <= cfg_wr_data;
                c32fd_pkg::REG_STORE_LENGTH:  store_length_reg  <= cfg_wr_data;
                c32fd_pkg::REG_STATUS_LENGTH: status_length_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    c32fd_crc_update u_crc (
        .crc_in  (crc_reg),
        .data_in (in_byte_reg),
        .crc_out (crc_upd)
    );

    // Expected header byte for the current hunt position
    always_comb begin
        case (position_reg[1:0])
            2'd0:    hdr_expect = c32fd_pkg::HDR0;
            2'd1:    hdr_expect = c32fd_pkg::HDR1;
            default: hdr_expect = c32fd_pkg::HDR2;
        endcase
    end

    assign pay_end   = c32fd_pkg::POS_PAYLOAD + {1'b0, length_reg};
    assign pos_plus  = position_reg + 9'd1;
    assign trail_end = pay_end + 9'd4;

    // Frame parser
    always_comb begin
        position_next = position_reg;
        command_next  = command_reg;
        length_next   = length_reg;
        crc_next      = crc_reg;
        rcv_crc_next  = rcv_crc_reg;
        res_valid     = 1'b0;
        res_byte      = 8'd0;
        res_offset    = 8'd0;
        res_end       = 1'b0;
        res_ok        = 1'b0;
        if (advance) begin
            if (in_kind_reg) begin
                // Line silence: drop any partial frame
                position_next = 9'd0;
                crc_next      = c32fd_pkg::CRC_INIT;
            end else if (position_reg < c32fd_pkg::POS_CMD) begin
                if (in_byte_reg == hdr_expect) begin
                    crc_next      = crc_upd;
                    position_next = pos_plus;
                end else begin
                    position_next = 9'd0;
                    crc_next      = c32fd_pkg::CRC_INIT;
                end
            end else if (position_reg == c32fd_pkg::POS_CMD) begin
                // Latch the payload length by command, drop unknown commands
                position_next = c32fd_pkg::POS_PAYLOAD;
                command_next  = in_byte_reg;
                crc_next      = crc_upd;
                rcv_crc_next  = 32'd0;
                case (in_byte_reg)
                    c32fd_pkg::CMD_INIT:   length_next = init_length_reg;
                    c32fd_pkg::CMD_STORE:  length_next = store_length_reg;
                    c32fd_pkg::CMD_STATUS: length_next = status_length_reg;
                    default: begin
                        position_next = 9'd0;
                        command_next  = command_reg;
                        crc_next      = c32fd_pkg::CRC_INIT;
                        rcv_crc_next  = rcv_crc_reg;
                    end
                endcase
            end else if (position_reg < pay_end) begin
                // Payload byte
                crc_next      = crc_upd;
                position_next = pos_plus;
                res_valid     = 1'b1;
                res_byte      = in_byte_reg;
                res_offset    = position_reg[7:0] - 8'd4;
            end else begin
                // Trailer byte, least significant first
                rcv_crc_next  = {in_byte_reg, rcv_crc_reg[31:8]};
                position_next = pos_plus;
                if (pos_plus >= trail_end) begin
                    res_valid     = 1'b1;
                    res_end       = 1'b1;
                    res_ok        = (rcv_crc_next == ~crc_reg);
                    position_next = 9'd0;
                    crc_next      = c32fd_pkg::CRC_INIT;
                end
            end
        end
    end

    // Frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= 9'd0;
            command_reg  <= 8'd0;
            length_reg   <= 8'd0;
            crc_reg      <= c32fd_pkg::CRC_INIT;
            rcv_crc_reg  <= 32'd0;
        end else begin
            position_reg <= position_next;
            command_reg  <= command_next;
            length_reg   <= length_next;
            crc_reg      <= crc_next;
            rcv_crc_reg  <= rcv_crc_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= res_valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && res_valid) begin
            m_command_reg        <= command_next;
            m_payload_byte_reg   <= res_byte;
            m_payload_offset_reg <= res_offset;
            m_frame_end_reg      <= res_end;
            m_crc_ok_reg         <= res_ok;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_command        = m_command_reg;
    assign m_payload_byte   = m_payload_byte_reg;
    assign m_payload_offset = m_payload_offset_reg;
    assign m_frame_end      = m_frame_end_reg;
    assign m_crc_ok         = m_crc_ok_reg;

endmodule

// ----- hw/rtl/c32fd_crc_update.sv -----
module c32fd_crc_update (
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [31:0] crc_out
);

    // Fold one byte into the running CRC, one bit per step, LSB first
    always_comb begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ c32fd_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule
